@@ rtl/rs485_pkg.sv @@
// Shared types and constants for the RS485 half-duplex frame buffer.
// No dependencies; imported by the top level.
`timescale 1ns / 1ps

package rs485_pkg;

   localparam int MODE_W  = 3;
   localparam int DATA_W  = 8;
   localparam int LIMIT_W = 16;
   localparam int KIND_W  = 2;
   localparam int COUNT_W = 7;
   localparam int TIMEOUT_W = 16;

   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd9;
   localparam logic [15:0] IDLE_MAX = 16'hFFFF;

   localparam logic [MODE_W-1:0] MODE_WRITE    = 3'd0;
   localparam logic [MODE_W-1:0] MODE_READ     = 3'd1;
   localparam logic [MODE_W-1:0] MODE_RX       = 3'd2;
   localparam logic [MODE_W-1:0] MODE_TX_READY = 3'd3;
   localparam logic [MODE_W-1:0] MODE_TX_DONE  = 3'd4;
   localparam logic [MODE_W-1:0] MODE_TICK     = 3'd5;

   localparam logic [KIND_W-1:0] KIND_STATUS    = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TX_BYTE   = 2'd1;
   localparam logic [KIND_W-1:0] KIND_HOST_BYTE = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NO_FRAME  = 2'd3;

   typedef enum logic [1:0] {
      PH_RECEIVING = 2'd0,
      PH_SENDING   = 2'd1,
      PH_DRAINING  = 2'd2
   } link_phase_type;

   typedef enum logic [1:0] {
      ST_IDLE     = 2'd0,
      ST_TX_FETCH = 2'd1,
      ST_FRAME    = 2'd2
   } ctrl_state_type;

endpackage

@@ rtl/rs485_ram.sv @@
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies; used for the transmit and receive byte buffers.
`timescale 1ns / 1ps

module rs485_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ rtl/rs485_half_duplex_frame_buffer_top.sv @@
// RS485 half-duplex byte buffer with idle-gap framing: control and state.
// Depends on rs485_pkg and two instances of rs485_ram.
//
//   Channel  Ports                                     Direction
//   req      req_valid/req_stall, mode data last limit  in
//   rsp      rsp_valid/rsp_stall, kind byte final de cnt out
//   csr      csr_wr_en, csr_wr_data (idle timeout)      in
//
// Single-result items are answered from the registered result. A transmitted
// byte is fetched through the transmit buffer's registered read port in ST_TX_FETCH.
// A host read returns one byte a cycle from the receive buffer's read port
// while rsp_stall is low. Reset is synchronous and needs no clearing pass.
// req_stall is high while an item is in progress or a result is not yet taken.
`timescale 1ns / 1ps

module rs485_half_duplex_frame_buffer_top #(
   parameter int BUFFER_DEPTH = 64
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [rs485_pkg::MODE_W-1:0]    req_mode,
   input  logic [rs485_pkg::DATA_W-1:0]    req_data,
   input  logic                            req_last,
   input  logic [rs485_pkg::LIMIT_W-1:0]   req_read_limit,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [rs485_pkg::KIND_W-1:0]    rsp_kind,
   output logic [rs485_pkg::DATA_W-1:0]    rsp_byte_out,
   output logic                            rsp_final_res,
   output logic                            rsp_driver_enable,
   output logic [rs485_pkg::COUNT_W-1:0]   rsp_byte_count,
   input  logic                            csr_wr_en,
   input  logic [rs485_pkg::TIMEOUT_W-1:0] csr_wr_data
);

   import rs485_pkg::*;

   localparam int AW = $clog2(BUFFER_DEPTH);
   localparam int CW = $clog2(BUFFER_DEPTH + 1);
   localparam logic [CW-1:0] DEPTH_C = CW'(BUFFER_DEPTH);

   ctrl_state_type        state_ff, state_in;
   link_phase_type        phase_ff, phase_in;
   logic                  driving_ff, driving_in;
   logic [CW-1:0]         tx_len_ff, tx_len_in;
   logic [CW-1:0]         tx_pos_ff, tx_pos_in;
   logic [CW-1:0]         rx_len_ff, rx_len_in;
   logic [15:0]           idle_ff, idle_in;
   logic [TIMEOUT_W-1:0]  timeout_ff, timeout_in;
   logic [CW-1:0]         total_ff, total_in;
   logic [CW-1:0]         issue_ff, issue_in;
   logic [CW-1:0]         got_ff, got_in;
   logic                  pend_ff, pend_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]     rsp_kind_ff, rsp_kind_in;
   logic [DATA_W-1:0]     rsp_byte_ff, rsp_byte_in;
   logic                  rsp_final_ff, rsp_final_in;
   logic                  rsp_de_ff, rsp_de_in;
   logic [COUNT_W-1:0]    rsp_count_ff, rsp_count_in;

   logic                  tx_we, tx_re, rx_we, rx_re;
   logic [AW-1:0]         tx_waddr, tx_raddr, rx_waddr, rx_raddr;
   logic [DATA_W-1:0]     tx_rd, rx_rd;
   logic                  out_free, load, last_byte;
   logic [CW-1:0]         frame_n;

   rs485_ram #(.WIDTH(DATA_W), .DEPTH(BUFFER_DEPTH)) u_tx_ram (
      .clock  (clock),
      .wr_en  (tx_we),
      .wr_addr(tx_waddr),
      .wr_data(req_data),
      .rd_en  (tx_re),
      .rd_addr(tx_raddr),
      .rd_data(tx_rd)
   );

   rs485_ram #(.WIDTH(DATA_W), .DEPTH(BUFFER_DEPTH)) u_rx_ram (
      .clock  (clock),
      .wr_en  (rx_we),
      .wr_addr(rx_waddr),
      .wr_data(req_data),
      .rd_en  (rx_re),
      .rd_addr(rx_raddr),
      .rd_data(rx_rd)
   );

   always_comb begin
      if (LIMIT_W'(rx_len_ff) <= req_read_limit) begin
         frame_n = rx_len_ff;
      end else begin
         frame_n = CW'(req_read_limit);
      end
   end

   always_comb begin
      state_in     = state_ff;
      phase_in     = phase_ff;
      driving_in   = driving_ff;
      tx_len_in    = tx_len_ff;
      tx_pos_in    = tx_pos_ff;
      rx_len_in    = rx_len_ff;
      idle_in      = idle_ff;
      timeout_in   = csr_wr_en ? csr_wr_data : timeout_ff;
      total_in     = total_ff;
      issue_in     = issue_ff;
      got_in       = got_ff;
      pend_in      = pend_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_byte_in  = rsp_byte_ff;
      rsp_final_in = rsp_final_ff;
      rsp_de_in    = rsp_de_ff;
      rsp_count_in = rsp_count_ff;
      tx_we        = 1'b0;
      tx_re        = 1'b0;
      tx_waddr     = tx_len_ff[AW-1:0];
      tx_raddr     = tx_pos_ff[AW-1:0];
      rx_we        = 1'b0;
      rx_re        = 1'b0;
      rx_waddr     = rx_len_ff[AW-1:0];
      rx_raddr     = issue_ff[AW-1:0];
      last_byte    = 1'b0;
      load         = 1'b0;
      out_free     = !rsp_valid_ff || !rsp_stall;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            req_stall = !out_free;
            if (req_valid && out_free) begin
               load         = 1'b1;
               rsp_kind_in  = KIND_STATUS;
               rsp_byte_in  = '0;
               rsp_final_in = 1'b1;
               rsp_count_in = '0;
               unique case (req_mode)
                  MODE_WRITE: begin
                     if (phase_ff == PH_RECEIVING) begin
                        if (tx_len_ff < DEPTH_C) begin
                           tx_we     = 1'b1;
                           tx_len_in = CW'(tx_len_ff + 1'b1);
                        end
                        if (req_last) begin
                           driving_in = 1'b1;
                           phase_in   = PH_SENDING;
                           tx_pos_in  = '0;
                        end
                        rsp_count_in = COUNT_W'(tx_len_in);
                     end
                  end
                  MODE_READ: begin
                     if (rx_len_ff == '0) begin
                        idle_in     = '0;
                        rsp_kind_in = KIND_NO_FRAME;
                     end else if (idle_ff < timeout_ff) begin
                        rsp_kind_in = KIND_NO_FRAME;
                     end else begin
                        rx_len_in = '0;
                        if (frame_n != '0) begin
                           load     = 1'b0;
                           rx_re    = 1'b1;
                           rx_raddr = '0;
                           issue_in = CW'(1);
                           got_in   = '0;
                           pend_in  = 1'b1;
                           total_in = frame_n;
                           state_in = ST_FRAME;
                        end
                     end
                  end
                  MODE_RX: begin
                     if (phase_ff == PH_RECEIVING) begin
                        rx_we = 1'b1;
                        if (rx_len_ff >= DEPTH_C) begin
                           rx_waddr  = '0;
                           rx_len_in = CW'(1);
                        end else begin
                           rx_len_in = CW'(rx_len_ff + 1'b1);
                        end
                        idle_in = '0;
                     end
                  end
                  MODE_TX_READY: begin
                     if (phase_ff == PH_SENDING) begin
                        if (tx_pos_ff < tx_len_ff) begin
                           tx_re     = 1'b1;
                           tx_pos_in = CW'(tx_pos_ff + 1'b1);
                           load      = 1'b0;
                           state_in  = ST_TX_FETCH;
                        end else begin
                           phase_in = PH_DRAINING;
                        end
                     end
                  end
                  MODE_TX_DONE: begin
                     if (phase_ff == PH_DRAINING) begin
                        driving_in = 1'b0;
                        phase_in   = PH_RECEIVING;
                        tx_len_in  = '0;
                        tx_pos_in  = '0;
                     end
                  end
                  MODE_TICK: begin
                     if (idle_ff != IDLE_MAX) begin
                        idle_in = idle_ff + 16'd1;
                     end
                  end
                  default: begin
                  end
               endcase
               if (load) begin
                  rsp_valid_in = 1'b1;
                  rsp_de_in    = driving_in;
               end
            end
         end
         ST_TX_FETCH: begin
            rsp_valid_in = 1'b1;
            rsp_kind_in  = KIND_TX_BYTE;
            rsp_byte_in  = tx_rd;
            rsp_final_in = 1'b1;
            rsp_de_in    = driving_ff;
            rsp_count_in = '0;
            state_in     = ST_IDLE;
         end
         ST_FRAME: begin
            if (pend_ff && out_free) begin
               last_byte    = (CW'(got_ff + 1'b1) == total_ff);
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_HOST_BYTE;
               rsp_byte_in  = rx_rd;
               rsp_final_in = last_byte;
               rsp_de_in    = driving_ff;
               rsp_count_in = COUNT_W'(total_ff);
               got_in       = CW'(got_ff + 1'b1);
               if (last_byte) begin
                  state_in = ST_IDLE;
               end
            end
            if ((issue_ff < total_ff) && (!pend_ff || out_free)) begin
               rx_re    = 1'b1;
               issue_in = CW'(issue_ff + 1'b1);
            end
            pend_in = rx_re || (pend_ff && !out_free);
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_RECEIVING;
         driving_ff   <= 1'b0;
         tx_len_ff    <= '0;
         tx_pos_ff    <= '0;
         rx_len_ff    <= '0;
         idle_ff      <= '0;
         timeout_ff   <= TIMEOUT_RESET;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         driving_ff   <= driving_in;
         tx_len_ff    <= tx_len_in;
         tx_pos_ff    <= tx_pos_in;
         rx_len_ff    <= rx_len_in;
         idle_ff      <= idle_in;
         timeout_ff   <= timeout_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      total_ff     <= total_in;
      issue_ff     <= issue_in;
      got_ff       <= got_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_byte_ff  <= rsp_byte_in;
      rsp_final_ff <= rsp_final_in;
      rsp_de_ff    <= rsp_de_in;
      rsp_count_ff <= rsp_count_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_byte_out      = rsp_byte_ff;
   assign rsp_final_res     = rsp_final_ff;
   assign rsp_driver_enable = rsp_de_ff;
   assign rsp_byte_count    = rsp_count_ff;

endmodule

@@ verif/rs485_half_duplex_frame_buffer_top_tb.sv @@
// Self-checking testbench for the RS485 half-duplex frame buffer top level.
// Holds its own model of the transmit and receive buffers and checks each transfer.
// Depends on rs485_pkg and the RTL of rs485_half_duplex_frame_buffer_top.
`timescale 1ns / 1ps

module rs485_half_duplex_frame_buffer_top_tb;
   import rs485_pkg::*;

   localparam int BUFFER_DEPTH = 64;
   localparam int CYCLE_LIMIT = 3000000;
   localparam logic [MODE_W-1:0] MODE_SPARE_LO = 3'd6;
   localparam logic [MODE_W-1:0] MODE_SPARE_HI = 3'd7;

   typedef struct packed {
      logic [KIND_W-1:0]  kind;
      logic [DATA_W-1:0]  byte_out;
      logic               final_res;
      logic               driver_enable;
      logic [COUNT_W-1:0] byte_count;
   } link_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_stall;
   logic [MODE_W-1:0]    req_mode = '0;
   logic [DATA_W-1:0]    req_data = '0;
   logic                 req_last = 1'b0;
   logic [LIMIT_W-1:0]   req_read_limit = '0;
   logic                 rsp_valid;
   logic                 rsp_stall = 1'b0;
   logic [KIND_W-1:0]    rsp_kind;
   logic [DATA_W-1:0]    rsp_byte_out;
   logic                 rsp_final_res;
   logic                 rsp_driver_enable;
   logic [COUNT_W-1:0]   rsp_byte_count;
   logic                 csr_wr_en = 1'b0;
   logic [TIMEOUT_W-1:0] csr_wr_data = '0;

   // Model of the block.
   logic [DATA_W-1:0]    tx_buf [BUFFER_DEPTH];
   logic [DATA_W-1:0]    rx_buf [BUFFER_DEPTH];
   int                   tx_len, tx_pos, rx_len;
   logic [15:0]          idle_cnt;
   link_phase_type       line_phase;
   logic                 drive_en;
   logic [TIMEOUT_W-1:0] idle_timeout;

   link_result_type      expected_link_out [$];
   link_result_type      rsp_seen, rsp_want;
   int                   errors = 0;
   int                   items_sent = 0;
   int                   cycle_count = 0;
   int                   send_idle_pct = 0;
   int                   rsp_stall_pct = 0;
   int                   hold_target = 0;
   int                   hold_served = 0;

   rs485_half_duplex_frame_buffer_top #(.BUFFER_DEPTH(BUFFER_DEPTH)) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_mode(req_mode),
      .req_data(req_data),
      .req_last(req_last),
      .req_read_limit(req_read_limit),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_kind(rsp_kind),
      .rsp_byte_out(rsp_byte_out),
      .rsp_final_res(rsp_final_res),
      .rsp_driver_enable(rsp_driver_enable),
      .rsp_byte_count(rsp_byte_count),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("rs485_half_duplex_frame_buffer_top_tb failed");
         $finish;
      end
   end

   // A long hold-off is requested by raising hold_target and counted here.
   always @(posedge clock) begin
      if (hold_served < hold_target) begin
         rsp_stall <= 1'b1;
         hold_served <= hold_served + 1;
      end else
         rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
   end

   function automatic logic [DATA_W-1:0] rand_byte();
      return DATA_W'($urandom_range(0, 255));
   endfunction

   function automatic logic [LIMIT_W-1:0] rand_limit();
      return LIMIT_W'($urandom_range(0, 65535));
   endfunction

   function automatic logic rand_bit();
      return 1'($urandom_range(0, 1));
   endfunction

   task automatic push_expected(input logic [KIND_W-1:0] kind, input logic [DATA_W-1:0] b,
                                input logic fin, input int count);
      link_result_type r;
      r.kind = kind;
      r.byte_out = b;
      r.final_res = fin;
      r.driver_enable = drive_en;
      r.byte_count = COUNT_W'(count);
      expected_link_out.push_back(r);
   endtask

   task automatic predict_link_event(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] data,
                                     input logic last, input logic [LIMIT_W-1:0] limit);
      int n;
      case (mode)
         MODE_WRITE: begin
            if (line_phase != PH_RECEIVING)
               push_expected(KIND_STATUS, 8'h00, 1'b1, 0);
            else begin
               if (tx_len < BUFFER_DEPTH) begin
                  tx_buf[tx_len] = data;
                  tx_len++;
               end
               if (last) begin
                  drive_en = 1'b1;
                  line_phase = PH_SENDING;
                  tx_pos = 0;
               end
               push_expected(KIND_STATUS, 8'h00, 1'b1, tx_len);
            end
         end
         MODE_READ: begin
            if (rx_len == 0) begin
               idle_cnt = '0;
               push_expected(KIND_NO_FRAME, 8'h00, 1'b1, 0);
            end else if (idle_cnt < idle_timeout)
               push_expected(KIND_NO_FRAME, 8'h00, 1'b1, 0);
            else begin
               n = (rx_len < int'(limit)) ? rx_len : int'(limit);
               rx_len = 0;
               if (n == 0)
                  push_expected(KIND_STATUS, 8'h00, 1'b1, 0);
               for (int i = 0; i < n; i++)
                  push_expected(KIND_HOST_BYTE, rx_buf[i], i == n - 1, n);
            end
         end
         MODE_RX: begin
            if (line_phase == PH_RECEIVING) begin
               if (rx_len >= BUFFER_DEPTH)
                  rx_len = 0;
               rx_buf[rx_len] = data;
               rx_len++;
               idle_cnt = '0;
            end
            push_expected(KIND_STATUS, 8'h00, 1'b1, 0);
         end
         MODE_TX_READY: begin
            if (line_phase == PH_SENDING && tx_pos < tx_len) begin
               push_expected(KIND_TX_BYTE, tx_buf[tx_pos], 1'b1, 0);
               tx_pos++;
            end else begin
               if (line_phase == PH_SENDING)
                  line_phase = PH_DRAINING;
               push_expected(KIND_STATUS, 8'h00, 1'b1, 0);
            end
         end
         MODE_TX_DONE: begin
            if (line_phase == PH_DRAINING) begin
               drive_en = 1'b0;
               line_phase = PH_RECEIVING;
               tx_len = 0;
               tx_pos = 0;
            end
            push_expected(KIND_STATUS, 8'h00, 1'b1, 0);
         end
         MODE_TICK: begin
            if (idle_cnt < IDLE_MAX)
               idle_cnt++;
            push_expected(KIND_STATUS, 8'h00, 1'b1, 0);
         end
         default:
            push_expected(KIND_STATUS, 8'h00, 1'b1, 0);
      endcase
   endtask

   task automatic compare_field(input string name, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            predict_link_event(req_mode, req_data, req_last, req_read_limit);
         if (rsp_valid && !rsp_stall) begin
            rsp_seen = {rsp_kind, rsp_byte_out, rsp_final_res, rsp_driver_enable, rsp_byte_count};
            if (expected_link_out.size() == 0) begin
               $display("%0t: unexpected result expected none actual kind %0d byte %0d count %0d",
                        $time, rsp_kind, rsp_byte_out, rsp_byte_count);
               errors++;
            end else begin
               rsp_want = expected_link_out.pop_front();
               compare_field("kind", int'(rsp_want.kind), int'(rsp_seen.kind));
               compare_field("byte_out", int'(rsp_want.byte_out), int'(rsp_seen.byte_out));
               compare_field("final_res", int'(rsp_want.final_res), int'(rsp_seen.final_res));
               compare_field("driver_enable", int'(rsp_want.driver_enable),
                             int'(rsp_seen.driver_enable));
               compare_field("byte_count", int'(rsp_want.byte_count),
                             int'(rsp_seen.byte_count));
            end
         end
      end
   end

   task automatic send_link_event(input logic [MODE_W-1:0] mode, input logic [DATA_W-1:0] data,
                                  input logic last, input logic [LIMIT_W-1:0] limit);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_mode <= mode;
      req_data <= data;
      req_last <= last;
      req_read_limit <= limit;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_link_out.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_idle_timeout(input logic [TIMEOUT_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      idle_timeout = value;
   endtask

   function automatic logic [LIMIT_W-1:0] pick_read_limit();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0)
         return '0;
      if (r == 1)
         return LIMIT_W'($urandom_range(0, 65535));
      return LIMIT_W'($urandom_range(1, 70));
   endfunction

   function automatic int pick_frame_len();
      if ($urandom_range(0, 19) < 2)
         return $urandom_range(60, 70);
      return $urandom_range(1, 8);
   endfunction

   task automatic send_tx_frame(input int len);
      int readies;
      readies = (len < BUFFER_DEPTH ? len : BUFFER_DEPTH) + 1;
      for (int i = 0; i < len; i++)
         send_link_event(MODE_WRITE, rand_byte(), i == len - 1, rand_limit());
      for (int i = 0; i < readies; i++)
         send_link_event(MODE_TX_READY, rand_byte(), rand_bit(), rand_limit());
      send_link_event(MODE_TX_DONE, rand_byte(), rand_bit(), rand_limit());
   endtask

   task automatic send_rx_frame(input int len, input int ticks, input logic [LIMIT_W-1:0] limit);
      for (int i = 0; i < len; i++)
         send_link_event(MODE_RX, rand_byte(), rand_bit(), rand_limit());
      for (int i = 0; i < ticks; i++)
         send_link_event(MODE_TICK, rand_byte(), rand_bit(), rand_limit());
      send_link_event(MODE_READ, rand_byte(), rand_bit(), limit);
   endtask

   task automatic send_noise();
      send_link_event(MODE_W'($urandom_range(0, 7)), rand_byte(), $urandom_range(0, 7) == 0,
                      pick_read_limit());
   endtask

   task automatic test_transmit_path();
      send_link_event(MODE_TX_READY, 8'h00, 1'b0, 16'h0000);
      send_link_event(MODE_TX_DONE, 8'h00, 1'b0, 16'h0000);
      send_link_event(MODE_WRITE, 8'h00, 1'b0, 16'h0000);
      send_link_event(MODE_WRITE, 8'hFF, 1'b1, 16'hFFFF);
      send_link_event(MODE_WRITE, 8'h5A, 1'b1, 16'h0000);
      send_link_event(MODE_RX, 8'h33, 1'b0, 16'h0000);
      repeat (3) send_link_event(MODE_TX_READY, 8'h00, 1'b0, 16'h0000);
      send_link_event(MODE_TX_READY, 8'h00, 1'b0, 16'h0000);
      send_link_event(MODE_TX_DONE, 8'h00, 1'b0, 16'h0000);
      wait_for_results();
   endtask

   task automatic test_receive_path();
      set_idle_timeout(16'd2);
      send_link_event(MODE_READ, 8'h00, 1'b0, 16'hFFFF);
      send_link_event(MODE_RX, 8'h00, 1'b0, 16'h0000);
      send_link_event(MODE_RX, 8'hFF, 1'b1, 16'hFFFF);
      send_link_event(MODE_READ, 8'h00, 1'b0, 16'hFFFF);
      repeat (2) send_link_event(MODE_TICK, 8'h00, 1'b0, 16'h0000);
      send_link_event(MODE_READ, 8'h00, 1'b0, 16'h0000);
      send_link_event(MODE_READ, 8'h00, 1'b0, 16'hFFFF);
      send_link_event(MODE_RX, 8'hA5, 1'b0, 16'h0000);
      send_link_event(MODE_RX, 8'h3C, 1'b0, 16'h0000);
      repeat (2) send_link_event(MODE_TICK, 8'h00, 1'b0, 16'h0000);
      send_link_event(MODE_READ, 8'h00, 1'b0, 16'h0001);
      send_link_event(MODE_SPARE_LO, 8'hFF, 1'b1, 16'hFFFF);
      send_link_event(MODE_SPARE_HI, 8'h00, 1'b0, 16'h0000);
      wait_for_results();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      set_idle_timeout(16'd9);
      hold_target <= hold_target + 400;
      send_rx_frame(40, 9, 16'd64);
      send_tx_frame(5);
      send_rx_frame(3, 9, 16'd64);
      wait_for_results();
   endtask

   task automatic test_idle_timeout();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      set_idle_timeout(16'hFFFF);
      send_rx_frame(2, 3, 16'hFFFF);
      wait_for_results();
      set_idle_timeout(16'd3);
      send_link_event(MODE_READ, 8'h00, 1'b0, 16'hFFFF);
      wait_for_results();
   endtask

   task automatic run_random_phase(input int idle_pct, input int stall_pct,
                                   input logic [TIMEOUT_W-1:0] timeout, input int item_count);
      int first_item, pick, ticks;
      wait_for_results();
      set_idle_timeout(timeout);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      first_item = items_sent;
      while (items_sent - first_item < item_count) begin
         pick = $urandom_range(0, 9);
         if (pick < 4) begin
            if (idle_timeout > 0 && $urandom_range(0, 4) == 0)
               ticks = $urandom_range(0, idle_timeout - 1);
            else
               ticks = idle_timeout + $urandom_range(0, 2);
            send_rx_frame(pick_frame_len(), ticks, pick_read_limit());
         end else if (pick < 7)
            send_tx_frame(pick_frame_len());
         else
            repeat ($urandom_range(1, 4)) send_noise();
      end
      wait_for_results();
   endtask

   initial begin
      tx_len = 0;
      tx_pos = 0;
      rx_len = 0;
      idle_cnt = '0;
      line_phase = PH_RECEIVING;
      drive_en = 1'b0;
      idle_timeout = TIMEOUT_RESET;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_transmit_path();
      test_receive_path();
      test_backpressure();
      test_idle_timeout();
      run_random_phase(0, 0, 16'd0, 40);
      run_random_phase(88, 0, TIMEOUT_W'($urandom_range(1, 12)), 40);
      run_random_phase(0, 88, 16'd1, 40);
      run_random_phase(13, 13, 16'd9, 40);
      if (errors == 0)
         $display("rs485_half_duplex_frame_buffer_top_tb passed");
      else
         $display("rs485_half_duplex_frame_buffer_top_tb failed");
      $finish;
   end

endmodule
